>>> sv/dplm_pkg.sv
// Shared constants and types for the demand-paged memory block.
`default_nettype none
package dplm_pkg;

    localparam int VIRT_PAGES  = 8;
    localparam int PHYS_FRAMES = 4;
    localparam int PAGE_WORDS  = 2;
    localparam int DATA_WIDTH  = 32;

    localparam int PAGE_W  = $clog2(VIRT_PAGES);
    localparam int FRAME_W = (PHYS_FRAMES > 1) ? $clog2(PHYS_FRAMES) : 1;
    localparam int OFF_W   = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
    localparam int ADDR_W  = 4;
    localparam int CNT_W   = $clog2(PHYS_FRAMES + 1);
    localparam int MAIN_DEPTH = PHYS_FRAMES * PAGE_WORDS;
    localparam int DISK_DEPTH = VIRT_PAGES * PAGE_WORDS;

    localparam logic [PAGE_W-1:0] LRU_EMPTY = PAGE_W'(7);

    typedef struct packed {
        logic               touch;
        logic [FRAME_W-1:0] frame;
    } t_lru_req;

endpackage
`default_nettype wire

>>> sv/dplm_lru.sv
// Recency list of physical frames, most recent first, with tail output.
`default_nettype none
module dplm_lru
    import dplm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_lru_req          i_req,
    output logic [PAGE_W-1:0]      o_tail
);

    logic [PAGE_W-1:0] r_order [PHYS_FRAMES];
    logic [PAGE_W-1:0] n_order [PHYS_FRAMES];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  w_pos;
    logic              w_hit;
    logic [CNT_W-1:0]  w_last;

    always_comb begin
        w_hit   = 1'b0;
        w_pos   = '0;
        n_count = r_count;
        for (int i = 0; i < PHYS_FRAMES; i++) begin
            if ((CNT_W'(i) < r_count) && (r_order[i] == PAGE_W'(i_req.frame))) begin
                w_hit = 1'b1;
                w_pos = CNT_W'(i);
            end
        end
        if (!w_hit) begin
            if (r_count < CNT_W'(PHYS_FRAMES)) begin
                n_count = r_count + CNT_W'(1);
            end
            w_pos = n_count - CNT_W'(1);
        end
        for (int i = 0; i < PHYS_FRAMES; i++) begin
            if (i == 0) begin
                n_order[i] = PAGE_W'(i_req.frame);
            end else if (CNT_W'(i) <= w_pos) begin
                n_order[i] = r_order[i-1];
            end else begin
                n_order[i] = r_order[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < PHYS_FRAMES; i++) begin
                r_order[i] <= LRU_EMPTY;
            end
        end else if (i_req.touch) begin
            r_count <= n_count;
            r_order <= n_order;
        end
    end

    assign w_last = r_count - CNT_W'(1);
    assign o_tail = (r_count != '0) ? r_order[w_last[FRAME_W-1:0]] : '0;

endmodule
`default_nettype wire

>>> sv/demand_paging_lru_memory.sv
// Top level: demand-paged memory with page table, LRU frame replacement and word stores.
// A hit goes from table lookup to access; a fault scans the page table and loads the page into
// a free frame or the least recent frame, writing that frame back first when a page owns it.
// An item occupies the block until its result is loaded into the output register; the fault
// path is set by the 8-entry page table scan and a read state and a write state per word moved.
// Synchronous active-low reset clears the page table, recency list and word valid bits;
// unwritten words read as all ones. No clearing pass follows reset.
`default_nettype none
module demand_paging_lru_memory
    import dplm_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_mode,
    input  wire logic        [ADDR_W-1:0]     i_vaddr,
    input  wire logic signed [DATA_WIDTH-1:0] i_wdata,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0]      o_rdata,
    output logic                              o_page_fault,
    output logic                              o_evicted,
    output logic        [PAGE_W-1:0]          o_victim_page,
    output logic        [FRAME_W-1:0]         o_frame_used
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_LOOK   = 10'b0000000010,
        S_SCAN   = 10'b0000000100,
        S_DECIDE = 10'b0000001000,
        S_WB_RD  = 10'b0000010000,
        S_WB_WR  = 10'b0000100000,
        S_LD_RD  = 10'b0001000000,
        S_LD_WR  = 10'b0010000000,
        S_ACC    = 10'b0100000000,
        S_FIN    = 10'b1000000000
    } t_state;

    t_state                  r_state;
    logic                    r_mode;
    logic [PAGE_W-1:0]       r_page;
    logic [OFF_W-1:0]        r_off;
    logic [DATA_WIDTH-1:0]   r_wdata;
    logic [PAGE_W-1:0]       r_idx;
    logic [PHYS_FRAMES-1:0]  r_used;
    logic                    r_found;
    logic [PAGE_W-1:0]       r_owner;
    logic [FRAME_W-1:0]      r_frame;
    logic                    r_fault;
    logic                    r_evict;
    logic [OFF_W-1:0]        r_word;
    logic                    r_valid [VIRT_PAGES];
    logic [PAGE_W-1:0]       r_slot  [VIRT_PAGES];

    logic [DATA_WIDTH-1:0]   r_main     [MAIN_DEPTH];
    logic                    r_main_vld [MAIN_DEPTH];
    logic [DATA_WIDTH-1:0]   r_main_q;
    logic                    r_main_q_vld;
    logic [DATA_WIDTH-1:0]   r_disk     [DISK_DEPTH];
    logic                    r_disk_vld [DISK_DEPTH];
    logic [DATA_WIDTH-1:0]   r_disk_q;
    logic                    r_disk_q_vld;

    logic                    r_out_valid;
    logic [DATA_WIDTH-1:0]   r_out_rdata;
    logic                    r_out_fault;
    logic                    r_out_evict;
    logic [PAGE_W-1:0]       r_out_victim;
    logic [FRAME_W-1:0]      r_out_frame;

    logic                    w_in_xfer;
    logic                    w_out_load;
    logic                    w_vld;
    logic [PAGE_W-1:0]       w_slot;
    logic [PAGE_W-1:0]       w_tail;
    logic                    w_tail_match;
    logic                    w_word_last;
    logic                    w_free_ok;
    logic [FRAME_W-1:0]      w_free;
    t_lru_req                w_lru_req;

    logic                              w_main_re;
    logic                              w_main_we;
    logic [FRAME_W+OFF_W-1:0]          w_main_ra;
    logic [FRAME_W+OFF_W-1:0]          w_main_wa;
    logic [DATA_WIDTH-1:0]             w_main_wd;
    logic [DATA_WIDTH-1:0]             w_main_rd;
    logic                              w_disk_re;
    logic                              w_disk_we;
    logic [PAGE_W+OFF_W-1:0]           w_disk_ra;
    logic [PAGE_W+OFF_W-1:0]           w_disk_wa;
    logic [DATA_WIDTH-1:0]             w_disk_rd;

    assign o_in_stall   = (r_state != S_IDLE);
    assign w_in_xfer    = i_in_valid && !o_in_stall;
    assign w_out_load   = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign w_vld        = r_valid[r_idx];
    assign w_slot       = r_slot[r_idx];
    assign w_tail_match = (w_slot == w_tail);
    assign w_word_last  = (r_word == OFF_W'(PAGE_WORDS - 1));

    always_comb begin
        w_free_ok = 1'b0;
        w_free    = '0;
        for (int i = PHYS_FRAMES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free_ok = 1'b1;
                w_free    = FRAME_W'(i);
            end
        end
    end

    assign w_lru_req.touch = (r_state == S_ACC);
    assign w_lru_req.frame = r_frame;

    dplm_lru u_lru (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_lru_req),
        .o_tail (w_tail)
    );

    assign w_main_re = (r_state == S_WB_RD) || ((r_state == S_ACC) && !r_mode);
    assign w_main_ra = {r_frame, (r_state == S_WB_RD) ? r_word : r_off};
    assign w_main_we = (r_state == S_LD_WR) || ((r_state == S_ACC) && r_mode);
    assign w_main_wa = {r_frame, (r_state == S_LD_WR) ? r_word : r_off};
    assign w_main_wd = (r_state == S_LD_WR) ? w_disk_rd : r_wdata;
    assign w_main_rd = r_main_q_vld ? r_main_q : '1;

    assign w_disk_re = (r_state == S_LD_RD);
    assign w_disk_ra = {r_page, r_word};
    assign w_disk_we = (r_state == S_WB_WR);
    assign w_disk_wa = {r_owner, r_word};
    assign w_disk_rd = r_disk_q_vld ? r_disk_q : '1;

    always_ff @(posedge i_clk) begin
        if (w_main_we) begin
            r_main[w_main_wa] <= w_main_wd;
        end
        if (w_main_re) begin
            r_main_q     <= r_main[w_main_ra];
            r_main_q_vld <= r_main_vld[w_main_ra];
        end
        if (w_disk_we) begin
            r_disk[w_disk_wa] <= w_main_rd;
        end
        if (w_disk_re) begin
            r_disk_q     <= r_disk[w_disk_ra];
            r_disk_q_vld <= r_disk_vld[w_disk_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAIN_DEPTH; i++) begin
                r_main_vld[i] <= 1'b0;
            end
            for (int i = 0; i < DISK_DEPTH; i++) begin
                r_disk_vld[i] <= 1'b0;
            end
        end else begin
            if (w_main_we) begin
                r_main_vld[w_main_wa] <= 1'b1;
            end
            if (w_disk_we) begin
                r_disk_vld[w_disk_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_mode  <= i_mode;
            r_page  <= i_vaddr[ADDR_W-1:OFF_W];
            r_off   <= i_vaddr[OFF_W-1:0];
            r_wdata <= i_wdata;
        end
        if (w_out_load) begin
            r_out_rdata  <= r_mode ? '0 : w_main_rd;
            r_out_fault  <= r_fault;
            r_out_evict  <= r_evict;
            r_out_victim <= r_evict ? r_owner : '0;
            r_out_frame  <= r_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_used      <= '0;
            r_found     <= 1'b0;
            r_owner     <= '0;
            r_frame     <= '0;
            r_fault     <= 1'b0;
            r_evict     <= 1'b0;
            r_word      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < VIRT_PAGES; i++) begin
                r_valid[i] <= 1'b0;
                r_slot[i]  <= PAGE_W'(i);
            end
        end else begin
            if (r_out_valid && !i_out_stall && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_idx   <= i_vaddr[ADDR_W-1:OFF_W];
                        r_fault <= 1'b0;
                        r_evict <= 1'b0;
                        r_word  <= '0;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (w_vld) begin
                        r_frame <= w_slot[FRAME_W-1:0];
                        r_state <= S_ACC;
                    end else begin
                        r_fault <= 1'b1;
                        r_idx   <= '0;
                        r_used  <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_vld && (w_slot < PAGE_W'(PHYS_FRAMES))) begin
                        r_used[w_slot[FRAME_W-1:0]] <= 1'b1;
                    end
                    if (w_vld && w_tail_match && !r_found) begin
                        r_found <= 1'b1;
                        r_owner <= r_idx;
                    end
                    if (r_idx == PAGE_W'(VIRT_PAGES - 1)) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx <= r_idx + PAGE_W'(1);
                    end
                end
                S_DECIDE: begin
                    if (w_free_ok) begin
                        r_frame <= w_free;
                        r_state <= S_LD_RD;
                    end else begin
                        r_frame <= w_tail[FRAME_W-1:0];
                        if (r_found) begin
                            r_evict <= 1'b1;
                            r_state <= S_WB_RD;
                        end else begin
                            r_state <= S_LD_RD;
                        end
                    end
                end
                S_WB_RD: begin
                    r_state <= S_WB_WR;
                end
                S_WB_WR: begin
                    if (w_word_last) begin
                        r_valid[r_owner] <= 1'b0;
                        r_slot[r_owner]  <= r_owner;
                        r_word           <= '0;
                        r_state          <= S_LD_RD;
                    end else begin
                        r_word  <= r_word + OFF_W'(1);
                        r_state <= S_WB_RD;
                    end
                end
                S_LD_RD: begin
                    r_state <= S_LD_WR;
                end
                S_LD_WR: begin
                    if (w_word_last) begin
                        r_valid[r_page] <= 1'b1;
                        r_slot[r_page]  <= PAGE_W'(r_frame);
                        r_word          <= '0;
                        r_state         <= S_ACC;
                    end else begin
                        r_word  <= r_word + OFF_W'(1);
                        r_state <= S_LD_RD;
                    end
                end
                S_ACC: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_load) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_rdata       = r_out_rdata;
    assign o_page_fault  = r_out_fault;
    assign o_evicted     = r_out_evict;
    assign o_victim_page = r_out_victim;
    assign o_frame_used  = r_out_frame;

    a_evict_needs_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_evicted || o_page_fault))
        else $error("eviction reported without page fault");

    a_xfer_starts_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_LOOK))
        else $error("input transfer did not start table lookup");

    a_fin_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("finished item did not reach output register");

    a_evict_path_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB_RD) |-> (r_evict && r_found && r_fault))
        else $error("write-back without a resident owner");

endmodule
`default_nettype wire
